// ===== design/odmm_pkg.sv =====
// Shared widths, codes, payload types and quarter-wave sine entry function for the omni drive mixer.
package odmm_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int SINE_ENTRIES = 1024;

  localparam int IDX_W       = $clog2(SINE_ENTRIES);
  localparam int QTR_W       = IDX_W - 2;
  localparam int QTR_ENTRIES = SINE_ENTRIES / 4;

  localparam int VALUE_W     = 16;
  localparam int HEADING_W   = 12;
  localparam int DUTY_W      = 8;
  localparam int DRIVE_W     = 3;
  localparam int MOTORS      = 4;
  localparam int MASK_W      = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam int ANGLE_W   = 12;
  localparam int THETA_W   = 13;
  localparam int NUM_W     = ANGLE_W + IDX_W;
  localparam int DIV_SHIFT = NUM_W + 12;
  localparam int MAGIC_W   = NUM_W + 1;

  localparam logic [63:0] DIV_MAGIC = ((64'd1 << DIV_SHIFT) + 64'd3599) / 64'd3600;
  localparam logic [MAGIC_W-1:0] MAGIC = DIV_MAGIC[MAGIC_W-1:0];

  localparam logic signed [THETA_W-1:0] THETA_BASE = 13'sd4050;
  localparam logic signed [THETA_W-1:0] FULL_TURN  = 13'sd3600;
  localparam logic [NUM_W-1:0]          ROUND_BIAS = NUM_W'(1800);

  localparam int QV_W    = FRAC_BITS + 1;
  localparam int SINE_W  = FRAC_BITS + 2;
  localparam int MIX_W   = VALUE_W + 1;
  localparam int WHEEL_W = VALUE_W + 2;
  localparam int CLAMP_W = FRAC_BITS + 2;
  localparam int CMP_W   = (WHEEL_W > CLAMP_W) ? WHEEL_W : CLAMP_W;
  localparam int PROD_W  = SINE_W + VALUE_W;
  localparam int DPROD_W = DUTY_W + 1 + CLAMP_W;

  localparam logic signed [PROD_W-1:0]  PROD_BIAS  = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [DPROD_W-1:0] DPROD_BIAS = DPROD_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [CMP_W-1:0]   ONE_C      = CMP_W'(64'd1 << FRAC_BITS);
  localparam logic signed [CMP_W-1:0]   NEG_ONE_C  = -ONE_C;

  localparam logic OP_POLAR = 1'b0;
  localparam logic OP_AXIS  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DUTY_A  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DUTY_B  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DUTY_C  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DUTY_D  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_MASK = 3'd4;

  localparam logic [DRIVE_W-1:0] DRIVE_OFF = 3'b000;
  localparam logic [DRIVE_W-1:0] DRIVE_REV = 3'b101;
  localparam logic [DRIVE_W-1:0] DRIVE_FWD = 3'b110;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] magnitude;
    logic signed [VALUE_W-1:0] turn;
    logic signed [MIX_W-1:0]   axis_ad;
    logic signed [MIX_W-1:0]   axis_bc;
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
  } angle_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] turn;
    logic signed [MIX_W-1:0]   ad;
    logic signed [MIX_W-1:0]   bc;
  } mix_t;

  typedef struct packed {
    logic [MOTORS-1:0][DUTY_W-1:0] max_duty;
    logic [MASK_W-1:0]             invert;
  } cfg_t;

  // sin(j / QTR_ENTRIES * pi/2) rounded to FRAC_BITS, series evaluated in Q30
  function automatic logic [QV_W-1:0] quarter_entry(input int j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] v;
    x   = (64'(j) * 64'd4 * HALF_PI_Q30) / SINE_ENTRIES;
    x2  = (x * x) >> 30;
    acc = ONE_Q30;
    acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd110;
    acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd72;
    acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd42;
    acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd20;
    acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd6;
    s   = (x * acc) >> 30;
    v   = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return v[QV_W-1:0];
  endfunction

  localparam logic [QV_W-1:0] QPEAK = quarter_entry(QTR_ENTRIES);

endpackage

// ===== design/odmm_angle.sv =====
// Heading wrap and table index by reciprocal multiply, two register stages.
module odmm_angle import odmm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [HEADING_W-1:0]        heading,
  input  logic signed [VALUE_W-1:0]   magnitude,
  input  logic signed [VALUE_W-1:0]   turn,
  input  logic signed [VALUE_W-1:0]   x_power,
  input  logic signed [VALUE_W-1:0]   y_power,
  output logic                        out_valid,
  input  logic                        out_ready,
  output angle_t                      out_word
);

  logic v1;
  logic v2;
  logic rdy1;
  logic rdy2;

  cmd_t             cmd1;
  cmd_t             cmd1_next;
  logic [NUM_W-1:0] num1;
  logic [NUM_W-1:0] num1_next;
  angle_t           word2;
  angle_t           word2_next;

  logic signed [THETA_W-1:0]    theta;
  logic [NUM_W+MAGIC_W-1:0]     quot_prod;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    theta = THETA_BASE - $signed({1'b0, heading});
    if (theta > FULL_TURN) begin
      theta = theta - FULL_TURN;
    end
    if (theta < 0) begin
      theta = theta + FULL_TURN;
    end
    num1_next = {theta[ANGLE_W-1:0], {IDX_W{1'b0}}} + ROUND_BIAS;
    cmd1_next.op        = operation;
    cmd1_next.magnitude = magnitude;
    cmd1_next.turn      = turn;
    cmd1_next.axis_ad   = MIX_W'(x_power) - MIX_W'(y_power);
    cmd1_next.axis_bc   = MIX_W'(x_power) + MIX_W'(y_power);
  end

  assign quot_prod = num1 * MAGIC;

  always_comb begin
    word2_next.cmd = cmd1;
    word2_next.idx = quot_prod[DIV_SHIFT +: IDX_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      cmd1 <= cmd1_next;
      num1 <= num1_next;
    end
    if (rdy2 && v1) begin
      word2 <= word2_next;
    end
  end

  assign out_valid = v2;
  assign out_word  = word2;

endmodule

// ===== design/odmm_trig.sv =====
// Sine and cosine lookup and scaling by power, two register stages.
module odmm_trig import odmm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  angle_t in_word,
  output logic   out_valid,
  input  logic   out_ready,
  output mix_t   out_word
);

  logic [QV_W-1:0] qrom [QTR_ENTRIES];

  for (genvar j = 0; j < QTR_ENTRIES; j++) begin : g_rom
    assign qrom[j] = quarter_entry(j);
  end

  logic v1;
  logic v2;
  logic rdy1;
  logic rdy2;

  cmd_t                     cmd1;
  logic signed [SINE_W-1:0] sin1;
  logic signed [SINE_W-1:0] cos1;
  logic signed [SINE_W-1:0] trig_next [2];
  mix_t                     word2;
  mix_t                     word2_next;

  logic [IDX_W-1:0]  look_idx  [2];
  logic [1:0]        look_quad [2];
  logic [QTR_W-1:0]  look_pos  [2];
  logic [QTR_W-1:0]  look_addr [2];
  logic [QV_W-1:0]   look_mag  [2];

  logic signed [PROD_W-1:0] sin_prod;
  logic signed [PROD_W-1:0] cos_prod;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    look_idx[0] = in_word.idx;
    look_idx[1] = in_word.idx + IDX_W'(QTR_ENTRIES);
    for (int t = 0; t < 2; t++) begin
      look_quad[t] = look_idx[t][IDX_W-1 -: 2];
      look_pos[t]  = look_idx[t][QTR_W-1:0];
      look_addr[t] = look_quad[t][0] ? QTR_W'(~look_pos[t] + QTR_W'(1)) : look_pos[t];
      if (look_quad[t][0] && (look_pos[t] == '0)) begin
        look_mag[t] = QPEAK;
      end else begin
        look_mag[t] = qrom[look_addr[t]];
      end
      if (look_quad[t][1]) begin
        trig_next[t] = -$signed({1'b0, look_mag[t]});
      end else begin
        trig_next[t] = $signed({1'b0, look_mag[t]});
      end
    end
  end

  always_comb begin
    sin_prod = PROD_W'(sin1) * PROD_W'(cmd1.magnitude);
    cos_prod = PROD_W'(cos1) * PROD_W'(cmd1.magnitude);
    if (sin_prod < 0) begin
      sin_prod = sin_prod + PROD_BIAS;
    end
    if (cos_prod < 0) begin
      cos_prod = cos_prod + PROD_BIAS;
    end
    word2_next.turn = cmd1.turn;
    if (cmd1.op == OP_AXIS) begin
      word2_next.ad = cmd1.axis_ad;
      word2_next.bc = cmd1.axis_bc;
    end else begin
      word2_next.ad = MIX_W'(sin_prod >>> FRAC_BITS);
      word2_next.bc = MIX_W'(cos_prod >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      cmd1 <= in_word.cmd;
      sin1 <= trig_next[0];
      cos1 <= trig_next[1];
    end
    if (rdy2 && v1) begin
      word2 <= word2_next;
    end
  end

  assign out_valid = v2;
  assign out_word  = word2;

endmodule

// ===== design/odmm_wheel.sv =====
// Wheel sums with clamp, then duty scaling and bridge pin select, two register stages.
module odmm_wheel import odmm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mix_t                          in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [MOTORS-1:0][DUTY_W-1:0] duty,
  output logic [MOTORS-1:0][DRIVE_W-1:0] drive
);

  logic v1;
  logic v2;
  logic rdy1;
  logic rdy2;

  logic signed [WHEEL_W-1:0] wheel      [MOTORS];
  logic signed [CMP_W-1:0]   wheel_cmp  [MOTORS];
  logic signed [CLAMP_W-1:0] clamp1     [MOTORS];
  logic signed [CLAMP_W-1:0] clamp1_next [MOTORS];

  logic signed [DPROD_W-1:0] dprod [MOTORS];
  logic signed [DUTY_W:0]    pw    [MOTORS];

  logic [MOTORS-1:0][DUTY_W-1:0]  duty2;
  logic [MOTORS-1:0][DUTY_W-1:0]  duty2_next;
  logic [MOTORS-1:0][DRIVE_W-1:0] drive2;
  logic [MOTORS-1:0][DRIVE_W-1:0] drive2_next;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    wheel[0] = WHEEL_W'(in_word.ad) + WHEEL_W'(in_word.turn);
    wheel[1] = WHEEL_W'(in_word.bc) + WHEEL_W'(in_word.turn);
    wheel[2] = WHEEL_W'(in_word.bc) - WHEEL_W'(in_word.turn);
    wheel[3] = WHEEL_W'(in_word.ad) - WHEEL_W'(in_word.turn);
    for (int m = 0; m < MOTORS; m++) begin
      wheel_cmp[m] = CMP_W'(wheel[m]);
      priority if (wheel_cmp[m] > ONE_C) begin
        clamp1_next[m] = CLAMP_W'(ONE_C);
      end else if (wheel_cmp[m] < NEG_ONE_C) begin
        clamp1_next[m] = CLAMP_W'(NEG_ONE_C);
      end else begin
        clamp1_next[m] = CLAMP_W'(wheel_cmp[m]);
      end
    end
  end

  always_comb begin
    for (int m = 0; m < MOTORS; m++) begin
      dprod[m] = $signed({1'b0, cfg.max_duty[m]}) * DPROD_W'(clamp1[m]);
      if (dprod[m] < 0) begin
        dprod[m] = dprod[m] + DPROD_BIAS;
      end
      pw[m] = (DUTY_W + 1)'(dprod[m] >>> FRAC_BITS);
      if (pw[m] == '0) begin
        duty2_next[m]  = '0;
        drive2_next[m] = DRIVE_OFF;
      end else if (pw[m] < 0) begin
        duty2_next[m]  = DUTY_W'(-pw[m]);
        drive2_next[m] = cfg.invert[m] ? DRIVE_FWD : DRIVE_REV;
      end else begin
        duty2_next[m]  = DUTY_W'(pw[m]);
        drive2_next[m] = cfg.invert[m] ? DRIVE_REV : DRIVE_FWD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      clamp1 <= clamp1_next;
    end
    if (rdy2 && v1) begin
      duty2  <= duty2_next;
      drive2 <= drive2_next;
    end
  end

  assign out_valid = v2;
  assign duty      = duty2;
  assign drive     = drive2;

endmodule

// ===== design/omni_drive_motor_mixer.sv =====
// Top level of the X-drive omni wheel mixer: config registers and the six-stage pipeline.
//
//   channel   signals                                        direction
//   cfg       cfg_write, cfg_index, cfg_data                 in
//   command   in_valid/in_ready, operation .. y_power        in
//   wheels    out_valid/out_ready, duty_a..d, drive_a..d     out
//
// One command word per cycle unless out_ready holds it back; six register stages:
// heading wrap, index multiply, table read, power multiply, clamp and duty multiply.
// An accepted word moves through these stages in order; the last drives the result ports.
// A stage holds its word while the next is full and stalled, so bubbles close up.
// Reset clears all stage valids, sets every max duty to 255 and the invert mask to 0.
module omni_drive_motor_mixer import odmm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [HEADING_W-1:0]      heading,
  input  logic signed [VALUE_W-1:0] magnitude,
  input  logic signed [VALUE_W-1:0] turn,
  input  logic signed [VALUE_W-1:0] x_power,
  input  logic signed [VALUE_W-1:0] y_power,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DUTY_W-1:0]         duty_a,
  output logic [DUTY_W-1:0]         duty_b,
  output logic [DUTY_W-1:0]         duty_c,
  output logic [DUTY_W-1:0]         duty_d,
  output logic [DRIVE_W-1:0]        drive_a,
  output logic [DRIVE_W-1:0]        drive_b,
  output logic [DRIVE_W-1:0]        drive_c,
  output logic [DRIVE_W-1:0]        drive_d
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_duty <= {MOTORS{DUTY_FULL}};
      cfg.invert   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_DUTY_A:  cfg.max_duty[0] <= cfg_data;
        REG_MAX_DUTY_B:  cfg.max_duty[1] <= cfg_data;
        REG_MAX_DUTY_C:  cfg.max_duty[2] <= cfg_data;
        REG_MAX_DUTY_D:  cfg.max_duty[3] <= cfg_data;
        REG_INVERT_MASK: cfg.invert      <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic   angle_valid;
  logic   angle_ready;
  angle_t angle_word;
  logic   mix_valid;
  logic   mix_ready;
  mix_t   mix_word;

  logic [MOTORS-1:0][DUTY_W-1:0]  duty;
  logic [MOTORS-1:0][DRIVE_W-1:0] drive;

  odmm_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .heading   (heading),
    .magnitude (magnitude),
    .turn      (turn),
    .x_power   (x_power),
    .y_power   (y_power),
    .out_valid (angle_valid),
    .out_ready (angle_ready),
    .out_word  (angle_word)
  );

  odmm_trig u_trig (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (angle_valid),
    .in_ready  (angle_ready),
    .in_word   (angle_word),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out_word  (mix_word)
  );

  odmm_wheel u_wheel (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_word   (mix_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .duty      (duty),
    .drive     (drive)
  );

  assign duty_a  = duty[0];
  assign duty_b  = duty[1];
  assign duty_c  = duty[2];
  assign duty_d  = duty[3];
  assign drive_a = drive[0];
  assign drive_b = drive[1];
  assign drive_c = drive[2];
  assign drive_d = drive[3];

`ifndef SYNTHESIS
  a_off_matches_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((duty_a == '0) == (drive_a == DRIVE_OFF)) &&
                   ((duty_b == '0) == (drive_b == DRIVE_OFF)) &&
                   ((duty_c == '0) == (drive_c == DRIVE_OFF)) &&
                   ((duty_d == '0) == (drive_d == DRIVE_OFF))))
    else $error("drive pins disagree with zero duty");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked while output side can advance");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present right after reset");
`endif

endmodule
